// ----- hdl/lbfn_pkg.sv -----
// Package for the Lorentzian bank flicker noise core.
// Field widths, parameter defaults, and the pipeline control struct.
// No dependencies.
package lbfn_pkg;

    localparam int GENERATORS_DEF = 64;
    localparam int SECTIONS_DEF   = 16;

    localparam int GEN_W   = 6;
    localparam int SEC_W   = 4;
    localparam int DECAY_W = 16;
    localparam int GAIN_W  = 24;
    localparam int NOISE_W = 16;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 40;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [GEN_W-1:0] gen;
    } stage_ctl_t;

endpackage

// ----- hdl/lbfn_if.sv -----
// Valid/ready channel interfaces for the flicker noise core.
// Depends on lbfn_pkg for field widths.
interface lbfn_in_if;
    import lbfn_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [GEN_W-1:0]          generator;
    logic [SEC_W-1:0]          section;
    logic [DECAY_W-1:0]        decay;
    logic [GAIN_W-1:0]         gain;
    logic signed [NOISE_W-1:0] noise;

    modport source (output valid, generator, section, decay, gain, noise, input ready);
    modport sink   (input valid, generator, section, decay, gain, noise, output ready);
endinterface

interface lbfn_out_if;
    import lbfn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [GEN_W-1:0]        generator_out;
    logic signed [SUM_W-1:0] flicker_sample;

    modport source (output valid, generator_out, flicker_sample, input ready);
    modport sink   (input valid, generator_out, flicker_sample, output ready);
endinterface

// ----- hdl/lorentzian_bank_flicker_noise_core.sv -----
// Top level of the Lorentzian bank flicker noise core.
// Depends on lbfn_pkg, lbfn_if, lbfn_ram, lbfn_update, lbfn_accum.
//
//  channel   dir  handshake            payload
//  items     in   valid / ready        generator section decay gain noise
//  results   out  valid / ready        generator_out flicker_sample
//  cfg       in   cfg_we               cfg_wdata (lorentzians_in_use)
//
// One transaction per cycle while items.ready is high; a result passes s1, s2, s3 and
// the output register after its last section. The section store is one RAM
// read/written per cycle; a transaction hitting the entry still in the multiply stage
// waits for its write-back. After reset all GENERATORS*SECTIONS entries are cleared,
// items.ready low. A stalled results transaction holds the whole pipeline and items.ready.
module lorentzian_bank_flicker_noise_core #(
    parameter int GENERATORS = lbfn_pkg::GENERATORS_DEF,
    parameter int SECTIONS   = lbfn_pkg::SECTIONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    lbfn_in_if.sink                    items,
    lbfn_out_if.source                 results,
    input  logic                       cfg_we,
    input  logic [lbfn_pkg::CFG_W-1:0] cfg_wdata
);
    import lbfn_pkg::*;

    localparam int DEPTH  = GENERATORS * SECTIONS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int USED_W = $clog2(SECTIONS + 1);

    logic [CFG_W-1:0]          cfg_reg;
    logic [USED_W-1:0]         used_eff;
    logic                      in_range;
    logic                      in_first;
    logic                      in_last;
    logic [31:0]               addr_full;
    logic [ADDR_W-1:0]         in_addr;
    logic                      hazard;
    logic                      accept;
    logic                      advance;

    logic                      clear_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;

    stage_ctl_t                s1_ctl_reg;
    logic [ADDR_W-1:0]         s1_addr_reg;
    logic [DECAY_W-1:0]        s1_decay_reg;
    logic [GAIN_W-1:0]         s1_gain_reg;
    logic signed [NOISE_W-1:0] s1_noise_reg;
    logic                      s1_fwd_reg;

    logic [VAL_W-1:0]          rd_data;
    logic                      s2_valid;
    logic [ADDR_W-1:0]         s2_addr;
    logic                      upd_we;
    logic [ADDR_W-1:0]         upd_addr;
    logic [VAL_W-1:0]          upd_data;
    stage_ctl_t                s3_ctl;
    logic signed [VAL_W-1:0]   s3_val;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [VAL_W-1:0]          ram_wdata;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            used_eff = USED_W'(1);
        end
        else if (32'(cfg_reg) > SECTIONS)
        begin
            used_eff = USED_W'(SECTIONS);
        end
        else
        begin
            used_eff = USED_W'(cfg_reg);
        end
    end

    always_comb
    begin
        in_range  = (32'(items.generator) < GENERATORS)
                 && (32'(items.section) < SECTIONS)
                 && (32'(items.section) < 32'(used_eff));
        in_first  = (items.section == '0);
        in_last   = (32'(items.section) == 32'(used_eff) - 32'd1);
        addr_full = 32'(items.generator) * 32'(SECTIONS) + 32'(items.section);
        in_addr   = addr_full[ADDR_W-1:0];
    end

    assign hazard      = s1_ctl_reg.valid && (s1_addr_reg == in_addr) && in_range;
    assign items.ready = !clear_reg && advance && !hazard;
    assign accept      = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s1_fwd_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_ctl_reg.valid <= accept && in_range;
            s1_ctl_reg.first <= in_first;
            s1_ctl_reg.last  <= in_last;
            s1_ctl_reg.gen   <= items.generator;
            s1_fwd_reg       <= s2_valid && (s2_addr == in_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_addr_reg  <= in_addr;
            s1_decay_reg <= items.decay;
            s1_gain_reg  <= items.gain;
            s1_noise_reg <= items.noise;
        end
    end

    always_comb
    begin
        ram_we    = clear_reg || upd_we;
        ram_waddr = clear_reg ? clr_addr_reg : upd_addr;
        ram_wdata = clear_reg ? '0 : upd_data;
    end

    lbfn_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_section_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    lbfn_update #(
        .ADDR_W (ADDR_W)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s1_ctl     (s1_ctl_reg),
        .s1_addr    (s1_addr_reg),
        .s1_decay   (s1_decay_reg),
        .s1_gain    (s1_gain_reg),
        .s1_noise   (s1_noise_reg),
        .s1_fwd_hit (s1_fwd_reg),
        .rd_data    (rd_data),
        .s2_valid   (s2_valid),
        .s2_addr    (s2_addr),
        .wr_en      (upd_we),
        .wr_addr    (upd_addr),
        .wr_data    (upd_data),
        .s3_ctl     (s3_ctl),
        .s3_val     (s3_val)
    );

    lbfn_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .s3_ctl  (s3_ctl),
        .s3_val  (s3_val),
        .advance (advance),
        .results (results)
    );

endmodule

// ----- hdl/lbfn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/lbfn_update.sv -----
// Section update datapath: multiply, round, saturate, write back.
// Holds the product and result stages plus the write-back bypass register.
// Depends on lbfn_pkg.
module lbfn_update #(
    parameter int ADDR_W = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  lbfn_pkg::stage_ctl_t               s1_ctl,
    input  logic [ADDR_W-1:0]                  s1_addr,
    input  logic [lbfn_pkg::DECAY_W-1:0]       s1_decay,
    input  logic [lbfn_pkg::GAIN_W-1:0]        s1_gain,
    input  logic signed [lbfn_pkg::NOISE_W-1:0] s1_noise,
    input  logic                               s1_fwd_hit,
    input  logic [lbfn_pkg::VAL_W-1:0]         rd_data,
    output logic                               s2_valid,
    output logic [ADDR_W-1:0]                  s2_addr,
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic [lbfn_pkg::VAL_W-1:0]         wr_data,
    output lbfn_pkg::stage_ctl_t               s3_ctl,
    output logic signed [lbfn_pkg::VAL_W-1:0]  s3_val
);
    import lbfn_pkg::*;

    localparam int PD_W  = DECAY_W + 1 + VAL_W;
    localparam int PN_W  = GAIN_W + 1 + NOISE_W;
    localparam int ACC_W = PD_W + 1;
    localparam int RND_W = ACC_W - 16;

    logic signed [VAL_W-1:0]     old_val;
    logic signed [DECAY_W:0]     decay_s;
    logic signed [GAIN_W:0]      gain_s;
    logic signed [PD_W-1:0]      prod_decay_next;
    logic signed [PN_W-1:0]      prod_noise_next;

    stage_ctl_t                  s2_ctl_reg;
    logic [ADDR_W-1:0]           s2_addr_reg;
    logic signed [PD_W-1:0]      prod_decay_reg;
    logic signed [PN_W-1:0]      prod_noise_reg;

    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     acc_rnd;
    logic signed [RND_W-1:0]     rnd;
    logic signed [VAL_W-1:0]     val_next;

    logic signed [VAL_W-1:0]     fwd_reg;
    stage_ctl_t                  s3_ctl_reg;
    logic signed [VAL_W-1:0]     s3_val_reg;

    assign old_val = s1_fwd_hit ? fwd_reg : $signed(rd_data);
    assign decay_s = $signed({1'b0, s1_decay});
    assign gain_s  = $signed({1'b0, s1_gain});

    always_comb
    begin
        prod_decay_next = PD_W'(decay_s) * PD_W'(old_val);
        prod_noise_next = PN_W'(gain_s) * PN_W'(s1_noise);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s2_ctl_reg <= s1_ctl;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_addr_reg    <= s1_addr;
            prod_decay_reg <= prod_decay_next;
            prod_noise_reg <= prod_noise_next;
            fwd_reg        <= val_next;
            s3_val_reg     <= val_next;
        end
    end

    // Q32 fraction sum, round half up to Q16, saturate to 32 bits.
    always_comb
    begin
        acc     = {prod_decay_reg[PD_W-1], prod_decay_reg}
                + {{(ACC_W-PN_W-4){prod_noise_reg[PN_W-1]}}, prod_noise_reg, 4'b0000};
        acc_rnd = acc + ACC_W'(32768);
        rnd     = acc_rnd[ACC_W-1:16];
        if (rnd[RND_W-1:VAL_W-1] == '0 || rnd[RND_W-1:VAL_W-1] == '1)
        begin
            val_next = rnd[VAL_W-1:0];
        end
        else if (rnd[RND_W-1])
        begin
            val_next = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            val_next = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign s2_valid = s2_ctl_reg.valid;
    assign s2_addr  = s2_addr_reg;
    assign wr_en    = advance && s2_ctl_reg.valid;
    assign wr_addr  = s2_addr_reg;
    assign wr_data  = val_next;
    assign s3_ctl   = s3_ctl_reg;
    assign s3_val   = s3_val_reg;

endmodule

// ----- hdl/lbfn_accum.sv -----
// Running sum over one generator's sections and the result output register.
// Produces the pipeline advance enable from output back-pressure.
// Depends on lbfn_pkg and lbfn_out_if.
module lbfn_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lbfn_pkg::stage_ctl_t              s3_ctl,
    input  logic signed [lbfn_pkg::VAL_W-1:0] s3_val,
    output logic                              advance,
    lbfn_out_if.source                        results
);
    import lbfn_pkg::*;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] val_ext;
    logic                    out_valid_reg;
    logic [GEN_W-1:0]        out_gen_reg;
    logic signed [SUM_W-1:0] out_sample_reg;

    assign val_ext  = SUM_W'(s3_val);
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + {val_ext[SUM_W-1], val_ext};

    always_comb
    begin
        if (s3_ctl.first)
        begin
            sum_next = val_ext;
        end
        else if (sum_wide[SUM_W] == sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        else if (sum_wide[SUM_W])
        begin
            sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            sum_next = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    assign advance = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s3_ctl.valid && s3_ctl.last;
            if (s3_ctl.valid)
            begin
                sum_reg <= s3_ctl.last ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_ctl.valid && s3_ctl.last)
        begin
            out_gen_reg    <= s3_ctl.gen;
            out_sample_reg <= sum_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.generator_out  = out_gen_reg;
    assign results.flicker_sample = out_sample_reg;

endmodule

// ----- hdl/lbfn_checker.sv -----
// Port-level assertions for the flicker noise core, and the bind that attaches them.
// Depends on lbfn_pkg and lorentzian_bank_flicker_noise_core.
module lbfn_checker #(
    parameter int GENERATORS = lbfn_pkg::GENERATORS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lbfn_pkg::GEN_W-1:0] out_generator,
    input logic [lbfn_pkg::SUM_W-1:0] out_sample
);
    import lbfn_pkg::*;

    // output transaction held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_generator) && $stable(out_sample))
        else $error("results payload changed while stalled");

    // a stalled result blocks new input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("items ready while results stalled");

    // store clear runs right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("items ready during store clear");

    a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_generator) < GENERATORS))
        else $error("result for nonexistent generator");

endmodule

bind lorentzian_bank_flicker_noise_core lbfn_checker #(
    .GENERATORS (GENERATORS)
) u_lbfn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (items.valid),
    .in_ready      (items.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_generator (results.generator_out),
    .out_sample    (results.flicker_sample)
);
